### hdl/bfs_pkg.sv
// Shared types and codes for the brightness fade stepper.
`timescale 1ns / 1ps

package bfs_pkg;

  localparam int LEVEL_W = 6;
  localparam int DIV_W   = 32;
  localparam int ACC_W   = 32;
  localparam int OP_W    = 2;
  localparam int DIR_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_BOUND = 2'd1;
  localparam logic [OP_W-1:0] OP_EXPL  = 2'd2;
  localparam logic [OP_W-1:0] OP_READ  = 2'd3;

  localparam logic [DIR_W-1:0] DIR_IDLE = 2'd0;
  localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LOWER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN = 2'd2;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 32'sh8000_0000;

  localparam logic signed [LEVEL_W-1:0] LOWER_RST = -6'sd16;
  localparam logic signed [LEVEL_W-1:0] UPPER_RST = 6'sd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SAT,
    ST_TICK,
    ST_CLAMP,
    ST_EMIT
  } bfs_state_t;

endpackage

### hdl/bfs_in_if.sv
// Command channel of the brightness fade stepper.
`timescale 1ns / 1ps

interface bfs_in_if;
  logic                                   valid;
  logic                                   ready;
  logic        [bfs_pkg::OP_W-1:0]        operation;
  logic        [bfs_pkg::DIR_W-1:0]       direction;
  logic signed [bfs_pkg::LEVEL_W-1:0]     start_level;
  logic signed [bfs_pkg::LEVEL_W-1:0]     target_level;
  logic signed [bfs_pkg::DIV_W-1:0]       divisor;

  modport source (
    output valid, operation, direction, start_level, target_level, divisor,
    input  ready
  );
  modport sink (
    input  valid, operation, direction, start_level, target_level, divisor,
    output ready
  );
endinterface

### hdl/bfs_out_if.sv
// Result channel of the brightness fade stepper.
`timescale 1ns / 1ps

interface bfs_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [bfs_pkg::LEVEL_W-1:0] level;
  logic                               screen_out;
  logic                               reply_kind;
  logic                               finished;

  modport source (
    output valid, level, screen_out, reply_kind, finished,
    input  ready
  );
  modport sink (
    input  valid, level, screen_out, reply_kind, finished,
    output ready
  );
endinterface

### hdl/brightness_fade_stepper_unit.sv
// Linear fixed-point brightness fade engine with a shared restoring divider.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+--------------------------------------------
//   in_ch    | in  | valid/ready        | operation, direction, start/target, divisor
//   out_ch   | out | valid/ready        | level, screen_out, reply_kind, finished
//   cfg_*    | in  | cfg_we, no ready   | cfg_index, cfg_data
//
// A fade start with a nonzero divisor runs the divider (ST_DIV) and then saturates the step
// (ST_SAT): one 34-bit compare/subtract produces one quotient bit per cycle.
// A start with a zero divisor, or a tick with no fade running, finishes in the idle state.
// A tick steps through add, clamp and emit; a level read goes straight to emit.
// Reset is synchronous on rst_n; it restores the register defaults and clears the fade.
// in_ch.ready is high only when the sequencer is idle; a result sits in the output
// register until taken, and a new result waits in the emit step while the old one stalls.
`timescale 1ns / 1ps

module brightness_fade_stepper_unit #(
  parameter int FRACTION_BITS = 12,
  parameter int LEVEL_LIMIT   = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  bfs_in_if.sink                             in_ch,
  bfs_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [bfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bfs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int NW = bfs_pkg::LEVEL_W + 2 * FRACTION_BITS;  // quotient magnitude bits
  localparam int CW = $clog2(NW);
  localparam int QW = ((NW > 32) ? NW : 32) + 1;
  localparam logic [QW-1:0] Q_POS_MAX = QW'(32'h7FFF_FFFF);
  localparam logic [QW-1:0] Q_NEG_MAX = QW'(32'h8000_0000);
  localparam logic signed [31:0] LIM_INT = 32'(LEVEL_LIMIT);
  localparam logic signed [31:0] LIM_FIX = 32'(LEVEL_LIMIT) <<< FRACTION_BITS;

  bfs_pkg::bfs_state_t state_r, state_nxt;

  logic signed [5:0]  lower_r, lower_nxt;
  logic signed [5:0]  upper_r, upper_nxt;
  logic               screen_r, screen_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic [1:0]         dir_r, dir_nxt;
  logic signed [5:0]  from_r, from_nxt;
  logic signed [5:0]  to_r, to_nxt;
  logic signed [31:0] step_r, step_nxt;

  logic [NW-1:0]      quo_r, quo_nxt;
  logic [31:0]        rem_r, rem_nxt;
  logic [31:0]        dmag_r, dmag_nxt;
  logic               neg_r, neg_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               kind_r, kind_nxt;
  logic               done_r, done_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic signed [5:0]  out_level_r, out_level_nxt;
  logic               out_screen_r, out_screen_nxt;
  logic               out_kind_r, out_kind_nxt;
  logic               out_done_r, out_done_nxt;

  logic               in_ready;
  logic signed [5:0]  st_from, st_to;
  logic signed [6:0]  diff;
  logic [6:0]         diff_neg;
  logic [5:0]         diff_mag;
  logic [31:0]        div_neg;
  logic [32:0]        rem_sh;
  logic [33:0]        rem_sub;
  logic [QW-1:0]      q_ext;
  logic signed [31:0] ip;
  logic               running;
  logic signed [32:0] sum;
  logic               is_start;

  always_comb begin
    state_nxt      = state_r;
    lower_nxt      = lower_r;
    upper_nxt      = upper_r;
    screen_nxt     = screen_r;
    acc_nxt        = acc_r;
    dir_nxt        = dir_r;
    from_nxt       = from_r;
    to_nxt         = to_r;
    step_nxt       = step_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    dmag_nxt       = dmag_r;
    neg_nxt        = neg_r;
    cnt_nxt        = cnt_r;
    kind_nxt       = kind_r;
    done_nxt       = done_r;
    out_valid_nxt  = out_valid_r;
    out_level_nxt  = out_level_r;
    out_screen_nxt = out_screen_r;
    out_kind_nxt   = out_kind_r;
    out_done_nxt   = out_done_r;
    is_start       = 1'b0;

    in_ready = (state_r == bfs_pkg::ST_IDLE);

    if (cfg_we) begin
      unique case (cfg_index)
        bfs_pkg::CFG_LOWER:  lower_nxt  = $signed(cfg_data);
        bfs_pkg::CFG_UPPER:  upper_nxt  = $signed(cfg_data);
        bfs_pkg::CFG_SCREEN: screen_nxt = cfg_data[0];
        default: ;
      endcase
    end

    // start operands and magnitudes for the divider
    if (in_ch.operation == bfs_pkg::OP_EXPL) begin
      st_from = in_ch.start_level;
      st_to   = in_ch.target_level;
    end else if (in_ch.direction == bfs_pkg::DIR_UP) begin
      st_from = lower_r;
      st_to   = upper_r;
    end else begin
      st_from = upper_r;
      st_to   = lower_r;
    end
    diff     = 7'(st_to) - 7'(st_from);
    diff_neg = 7'(-diff);
    diff_mag = diff[6] ? diff_neg[5:0] : diff[5:0];
    div_neg  = 32'(-in_ch.divisor);

    rem_sh  = {rem_r, quo_r[NW-1]};
    rem_sub = {1'b0, rem_sh} - {2'b00, dmag_r};
    q_ext   = QW'(quo_r);

    ip      = acc_r >>> FRACTION_BITS;
    running = (dir_r == bfs_pkg::DIR_UP) ? (ip < 32'(to_r)) : (ip > 32'(to_r));
    sum     = 33'(acc_r) + 33'(step_r);

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      bfs_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          unique case (in_ch.operation)
            bfs_pkg::OP_TICK: begin
              if (dir_r == bfs_pkg::DIR_UP || dir_r == bfs_pkg::DIR_DOWN) begin
                state_nxt = bfs_pkg::ST_TICK;
              end
            end
            bfs_pkg::OP_BOUND: begin
              dir_nxt = in_ch.direction;
              is_start = (in_ch.direction == bfs_pkg::DIR_UP) ||
                         (in_ch.direction == bfs_pkg::DIR_DOWN);
            end
            bfs_pkg::OP_EXPL: begin
              is_start = 1'b1;
              if (in_ch.start_level < in_ch.target_level) begin
                dir_nxt = bfs_pkg::DIR_UP;
              end else if (in_ch.start_level > in_ch.target_level) begin
                dir_nxt = bfs_pkg::DIR_DOWN;
              end
            end
            bfs_pkg::OP_READ: begin
              kind_nxt  = bfs_pkg::KIND_READ;
              done_nxt  = 1'b0;
              state_nxt = bfs_pkg::ST_EMIT;
            end
            default: ;
          endcase
          if (is_start) begin
            from_nxt = st_from;
            to_nxt   = st_to;
            acc_nxt  = 32'(st_from) <<< FRACTION_BITS;
            if (in_ch.divisor == '0) begin
              if (diff > 0) begin
                step_nxt = bfs_pkg::ACC_MAX;
              end else if (diff < 0) begin
                step_nxt = bfs_pkg::ACC_MIN;
              end else begin
                step_nxt = '0;
              end
            end else begin
              quo_nxt   = {diff_mag, (2 * FRACTION_BITS)'(0)};
              rem_nxt   = '0;
              dmag_nxt  = in_ch.divisor[31] ? div_neg : in_ch.divisor;
              neg_nxt   = diff[6] ^ in_ch.divisor[31];
              cnt_nxt   = '0;
              state_nxt = bfs_pkg::ST_DIV;
            end
          end
        end
      end
      bfs_pkg::ST_DIV: begin
        // shift one numerator bit into the remainder and one quotient bit into quo_r
        quo_nxt = {quo_r[NW-2:0], ~rem_sub[33]};
        rem_nxt = rem_sub[33] ? rem_sh[31:0] : rem_sub[31:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          state_nxt = bfs_pkg::ST_SAT;
        end
      end
      bfs_pkg::ST_SAT: begin
        if (neg_r) begin
          step_nxt = (q_ext > Q_NEG_MAX) ? bfs_pkg::ACC_MIN : 32'(-q_ext[31:0]);
        end else begin
          step_nxt = (q_ext > Q_POS_MAX) ? bfs_pkg::ACC_MAX : $signed(q_ext[31:0]);
        end
        state_nxt = bfs_pkg::ST_IDLE;
      end
      bfs_pkg::ST_TICK: begin
        if (running) begin
          if (sum[32] != sum[31]) begin
            acc_nxt = sum[32] ? bfs_pkg::ACC_MIN : bfs_pkg::ACC_MAX;
          end else begin
            acc_nxt = sum[31:0];
          end
          done_nxt = 1'b0;
        end else begin
          acc_nxt  = 32'(to_r) <<< FRACTION_BITS;
          dir_nxt  = bfs_pkg::DIR_IDLE;
          done_nxt = 1'b1;
        end
        kind_nxt  = bfs_pkg::KIND_TICK;
        state_nxt = bfs_pkg::ST_CLAMP;
      end
      bfs_pkg::ST_CLAMP: begin
        if (ip > LIM_INT) begin
          acc_nxt = LIM_FIX;
        end else if (ip < -LIM_INT) begin
          acc_nxt = -LIM_FIX;
        end
        state_nxt = bfs_pkg::ST_EMIT;
      end
      bfs_pkg::ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_level_nxt  = ip[5:0];
          out_screen_nxt = screen_r;
          out_kind_nxt   = kind_r;
          out_done_nxt   = done_r;
          state_nxt      = bfs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bfs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r     <= bfs_pkg::LOWER_RST;
      upper_r     <= bfs_pkg::UPPER_RST;
      screen_r    <= 1'b0;
      acc_r       <= '0;
      dir_r       <= bfs_pkg::DIR_IDLE;
      from_r      <= '0;
      to_r        <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      lower_r     <= lower_nxt;
      upper_r     <= upper_nxt;
      screen_r    <= screen_nxt;
      acc_r       <= acc_nxt;
      dir_r       <= dir_nxt;
      from_r      <= from_nxt;
      to_r        <= to_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    dmag_r       <= dmag_nxt;
    neg_r        <= neg_nxt;
    cnt_r        <= cnt_nxt;
    kind_r       <= kind_nxt;
    done_r       <= done_nxt;
    out_level_r  <= out_level_nxt;
    out_screen_r <= out_screen_nxt;
    out_kind_r   <= out_kind_nxt;
    out_done_r   <= out_done_nxt;
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.level      = out_level_r;
  assign out_ch.screen_out = out_screen_r;
  assign out_ch.reply_kind = out_kind_r;
  assign out_ch.finished   = out_done_r;

endmodule
